FILE: hdl/wfp_pkg.sv
// shared codes, constants and types of the websocket frame parser
`default_nettype none

package wfp_pkg;

    // parser phases
    localparam logic [2:0] PH_HDR1    = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_LEN16   = 3'd2;
    localparam logic [2:0] PH_LEN64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    localparam logic [7:0] RSV_MASK    = 8'h70;
    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [7:0] TOP_BIT     = 8'h80;
    localparam logic [7:0] LEN7_MASK   = 8'h7F;
    localparam logic [6:0] LEN_CODE16  = 7'd126;
    localparam logic [6:0] LEN_CODE64  = 7'd127;
    localparam logic [3:0] OPCODE_MAX  = 4'd10;
    localparam logic [15:0] LEN16_MIN  = 16'd126;

    localparam logic [2:0] LEN16_LAST = 3'd1;
    localparam logic [2:0] LEN64_LAST = 3'd7;
    localparam logic [1:0] KEY_LAST   = 2'd3;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        header_done;
        logic        frame_done;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        masked;
        logic [62:0] decoded_length;
        logic        error;
    } wfp_result_t;

endpackage

`default_nettype wire

FILE: hdl/wfp_if.sv
// request channels of the websocket frame parser: byte stream in, result out
`default_nettype none

interface wfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface wfp_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        header_done;
    logic        frame_done;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [62:0] decoded_length;
    logic        error;

    modport source (
        output valid, input ready,
        output payload_valid, output payload_byte, output payload_last,
        output header_done, output frame_done, output fin_flag,
        output frame_opcode, output masked, output decoded_length, output error
    );
    modport sink (
        input valid, output ready,
        input payload_valid, input payload_byte, input payload_last,
        input header_done, input frame_done, input fin_flag,
        input frame_opcode, input masked, input decoded_length, input error
    );
endinterface

`default_nettype wire

FILE: hdl/wfp_parse_core.sv
// parser state and the single-pass next-state and result logic for one byte
`default_nettype none

module wfp_parse_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           data_byte,
    output wfp_pkg::wfp_result_t      result
);
    import wfp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [63:0] accum_reg, accum_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_idx_reg, key_idx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic        error_reg, error_next;

    logic        len_known;
    logic        pay_valid;
    logic [7:0]  pay_byte;
    logic        pay_last;
    logic        hdr_done;
    logic        frm_done;
    logic [6:0]  len_code;
    logic [15:0] acc16;
    logic [63:0] acc64;
    logic [7:0]  key_byte;
    logic        len_ok;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        accum_next   = accum_reg;
        remain_next  = remain_reg;
        key_next     = key_reg;
        key_idx_next = key_idx_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        error_next   = error_reg;
        len_known    = 1'b0;
        pay_valid    = 1'b0;
        pay_byte     = 8'd0;
        pay_last     = 1'b0;
        hdr_done     = 1'b0;
        frm_done     = 1'b0;
        len_code     = data_byte[6:0] & LEN7_MASK[6:0];
        acc16        = {accum_reg[7:0], data_byte};
        acc64        = {accum_reg[55:0], data_byte};
        key_byte     = mask_reg ? key_reg[{key_idx_reg, 3'b000} +: 8] : 8'd0;

        if (!error_reg)
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    mask_next  = |(data_byte & TOP_BIT);
                    count_next = 3'd0;
                    accum_next = 64'd0;
                    if (len_code < LEN_CODE16)
                    begin
                        accum_next = {57'd0, len_code};
                        len_known  = 1'b1;
                    end
                    else if (len_code == LEN_CODE16)
                    begin
                        phase_next = PH_LEN16;
                    end
                    else
                    begin
                        phase_next = PH_LEN64;
                    end
                end
                PH_LEN16:
                begin
                    accum_next = {48'd0, acc16};
                    if (count_reg == LEN16_LAST)
                    begin
                        if (acc16 < LEN16_MIN)
                            error_next = 1'b1;
                        else
                            len_known = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_LEN64:
                begin
                    accum_next = acc64;
                    if (count_reg == LEN64_LAST)
                    begin
                        // must exceed the 16-bit range and keep the top bit clear
                        if (acc64[63] || (acc64[63:16] == 48'd0))
                            error_next = 1'b1;
                        else
                            len_known = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_next[{count_reg[1:0], 3'b000} +: 8] = data_byte;
                    if (count_reg[1:0] == KEY_LAST)
                    begin
                        hdr_done   = 1'b1;
                        count_next = 3'd0;
                        if (remain_reg == 64'd0)
                        begin
                            frm_done   = 1'b1;
                            phase_next = PH_HDR1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_valid    = 1'b1;
                    pay_byte     = data_byte ^ key_byte;
                    key_idx_next = key_idx_reg + 2'd1;
                    remain_next  = remain_reg - 64'd1;
                    if (remain_reg == 64'd1)
                    begin
                        pay_last   = 1'b1;
                        frm_done   = 1'b1;
                        phase_next = PH_HDR1;
                    end
                end
                default:
                begin
                    fin_next     = |(data_byte & TOP_BIT);
                    opcode_next  = data_byte[3:0] & OPCODE_MASK[3:0];
                    mask_next    = 1'b0;
                    accum_next   = 64'd0;
                    remain_next  = 64'd0;
                    count_next   = 3'd0;
                    key_idx_next = 2'd0;
                    if (((data_byte & RSV_MASK) != 8'd0) || (opcode_next > OPCODE_MAX))
                        error_next = 1'b1;
                    else
                        phase_next = PH_HDR2;
                end
            endcase

            // length settled: go to the key, the payload or close an empty frame
            if (len_known)
            begin
                remain_next  = accum_next;
                count_next   = 3'd0;
                key_idx_next = 2'd0;
                if (mask_next)
                begin
                    phase_next = PH_KEY;
                end
                else
                begin
                    hdr_done = 1'b1;
                    if (accum_next == 64'd0)
                    begin
                        frm_done   = 1'b1;
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
        end

        len_ok = (phase_next == PH_KEY) || (phase_next == PH_PAYLOAD) || frm_done;

        result.payload_valid  = pay_valid;
        result.payload_byte   = pay_byte;
        result.payload_last   = pay_last;
        result.header_done    = hdr_done;
        result.frame_done     = frm_done;
        result.fin_flag       = fin_next;
        result.frame_opcode   = opcode_next;
        result.masked         = mask_next;
        result.decoded_length = len_ok ? accum_next[62:0] : 63'd0;
        result.error          = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR1;
            count_reg   <= 3'd0;
            accum_reg   <= 64'd0;
            remain_reg  <= 64'd0;
            key_reg     <= 32'd0;
            key_idx_reg <= 2'd0;
            fin_reg     <= 1'b0;
            opcode_reg  <= 4'd0;
            mask_reg    <= 1'b0;
            error_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            accum_reg   <= accum_next;
            remain_reg  <= remain_next;
            key_reg     <= key_next;
            key_idx_reg <= key_idx_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            error_reg   <= error_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wfp_result_reg.sv
// result register driving the output channel
`default_nettype none

module wfp_result_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire wfp_pkg::wfp_result_t result,
    output logic                      can_load,
    wfp_out_if.source                 frame_out
);
    import wfp_pkg::*;

    logic        valid_reg, valid_next;
    wfp_result_t data_reg;

    assign can_load = !valid_reg || frame_out.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (frame_out.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign frame_out.valid          = valid_reg;
    assign frame_out.payload_valid  = data_reg.payload_valid;
    assign frame_out.payload_byte   = data_reg.payload_byte;
    assign frame_out.payload_last   = data_reg.payload_last;
    assign frame_out.header_done    = data_reg.header_done;
    assign frame_out.frame_done     = data_reg.frame_done;
    assign frame_out.fin_flag       = data_reg.fin_flag;
    assign frame_out.frame_opcode   = data_reg.frame_opcode;
    assign frame_out.masked         = data_reg.masked;
    assign frame_out.decoded_length = data_reg.decoded_length;
    assign frame_out.error          = data_reg.error;

endmodule

`default_nettype wire

FILE: hdl/websocket_frame_parser_unit.sv
// websocket frame parser top level: input register, parse core, result register
//
//   channel    | dir | payload                               | request
//   byte_in    | in  | data_byte                             | one raw stream byte
//   frame_out  | out | payload fields, header/frame markers  | one result per byte
//
// one byte per cycle sustained while frame_out is ready; a result is presented once its byte
// has passed the input register, then the parse logic into the result register
// the frame state updates once per byte as it moves into the result register
// reset clears the parser to the first header byte with no error
// a stalled result holds in its register while one more byte waits in the input register
`default_nettype none

module websocket_frame_parser_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    wfp_in_if.sink    byte_in,
    wfp_out_if.source frame_out
);
    import wfp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        can_load;
    logic        advance;
    logic        accept;
    wfp_result_t result;

    assign advance       = in_valid_reg && can_load;
    assign byte_in.ready = !in_valid_reg || can_load;
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= byte_in.data_byte;
    end

    wfp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .result    (result)
    );

    wfp_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .can_load  (can_load),
        .frame_out (frame_out)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_websocket_frame_parser_unit.sv
// self-checking testbench of the websocket frame parser: frame streams in, per-byte results checked
module tb_websocket_frame_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wfp_pkg::*;

    typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;
    typedef enum int unsigned {
        END_RSV, END_OPCODE, END_LEN16_SHORT, END_LEN64_SMALL, END_LEN64_TOP, END_HUGE
    } stream_end_e;

    localparam logic [3:0] OP_TEXT   = 4'h1;

    logic clk;
    logic rst_n;

    wfp_in_if  byte_in ();
    wfp_out_if frame_out ();

    websocket_frame_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in.sink),
        .frame_out (frame_out.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // parser state as the block should hold it
    logic [2:0]  hdr_phase    = PH_HDR1;
    logic [2:0]  len_count    = '0;
    logic [63:0] len_value    = '0;
    logic [63:0] payload_left = '0;
    logic [31:0] key_bytes    = '0;
    logic [1:0]  key_pos      = '0;
    logic        fin_seen     = 1'b0;
    logic [3:0]  opcode_seen  = '0;
    logic        mask_seen    = 1'b0;
    logic        err_seen     = 1'b0;

    logic [7:0]  raw_stream[$];
    wfp_result_t parsed_results[$];
    int unsigned mismatches = 0;

    logic        in_fire = 1'b0;
    int unsigned drv_gap = 0;
    bit          drv_quiet = 1'b0;
    int unsigned sink_cycles = 0;
    int unsigned sink_stall = 0;
    int unsigned hold_left = 0;
    bit          sink_quiet = 1'b0;

    task automatic length_decoded(inout logic hdr, inout logic fdone);
        payload_left = len_value;
        len_count = '0;
        key_pos = '0;
        if (mask_seen)
        begin
            hdr_phase = PH_KEY;
        end
        else
        begin
            hdr = 1'b1;
            if (len_value == 0)
            begin
                fdone = 1'b1;
                hdr_phase = PH_HDR1;
            end
            else
            begin
                hdr_phase = PH_PAYLOAD;
            end
        end
    endtask

    task automatic parse_ws_byte(input logic [7:0] b, output wfp_result_t r);
        logic       hdr;
        logic       fdone;
        logic       len_ok;
        logic [7:0] k;
        r = '0;
        hdr = 1'b0;
        fdone = 1'b0;
        if (!err_seen)
        begin
            case (hdr_phase)
                PH_HDR2:
                begin
                    mask_seen = b[7];
                    len_value = '0;
                    len_count = '0;
                    if (b[6:0] < LEN_CODE16)
                    begin
                        len_value = 64'(b[6:0]);
                        length_decoded(hdr, fdone);
                    end
                    else if (b[6:0] == LEN_CODE16)
                    begin
                        hdr_phase = PH_LEN16;
                    end
                    else
                    begin
                        hdr_phase = PH_LEN64;
                    end
                end
                PH_LEN16:
                begin
                    len_value = {48'd0, len_value[7:0], b};
                    if (len_count == LEN16_LAST)
                    begin
                        if (len_value < LEN16_MIN)
                            err_seen = 1'b1;
                        else
                            length_decoded(hdr, fdone);
                    end
                    else
                    begin
                        len_count = len_count + 3'd1;
                    end
                end
                PH_LEN64:
                begin
                    len_value = {len_value[55:0], b};
                    if (len_count == LEN64_LAST)
                    begin
                        if (len_value <= 64'hFFFF || len_value[63])
                            err_seen = 1'b1;
                        else
                            length_decoded(hdr, fdone);
                    end
                    else
                    begin
                        len_count = len_count + 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_bytes[8*len_count[1:0] +: 8] = b;
                    if (len_count[1:0] == KEY_LAST)
                    begin
                        hdr = 1'b1;
                        len_count = '0;
                        if (payload_left == 0)
                        begin
                            fdone = 1'b1;
                            hdr_phase = PH_HDR1;
                        end
                        else
                        begin
                            hdr_phase = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        len_count = len_count + 3'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    k = mask_seen ? key_bytes[8*key_pos +: 8] : 8'h00;
                    r.payload_valid = 1'b1;
                    r.payload_byte = b ^ k;
                    key_pos = key_pos + 2'd1;
                    payload_left = payload_left - 64'd1;
                    if (payload_left == 0)
                    begin
                        r.payload_last = 1'b1;
                        fdone = 1'b1;
                        hdr_phase = PH_HDR1;
                    end
                end
                default:
                begin
                    // first header byte; unused phase codes land here too
                    fin_seen = b[7];
                    opcode_seen = b[3:0];
                    mask_seen = 1'b0;
                    len_value = '0;
                    payload_left = '0;
                    len_count = '0;
                    key_pos = '0;
                    if ((b & RSV_MASK) != 0 || opcode_seen > OPCODE_MAX)
                        err_seen = 1'b1;
                    else
                        hdr_phase = PH_HDR2;
                end
            endcase
        end
        // length is shown once decoded, and held through key and payload
        len_ok = (!err_seen || hdr_phase == PH_KEY || hdr_phase == PH_PAYLOAD)
                 && (hdr_phase == PH_KEY || hdr_phase == PH_PAYLOAD || fdone);
        r.header_done = hdr;
        r.frame_done = fdone;
        r.fin_flag = fin_seen;
        r.frame_opcode = opcode_seen;
        r.masked = mask_seen;
        r.decoded_length = len_ok ? len_value[62:0] : '0;
        r.error = err_seen;
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] random_hdr1();
        return {1'($urandom), 3'b000, 4'($urandom_range(0, OPCODE_MAX))};
    endfunction

    task automatic add_frame(input logic [7:0] first, input logic mask_on,
                             input logic [63:0] len, input len_form_e form,
                             input int unsigned payload_count);
        raw_stream.push_back(first);
        case (form)
            LEN_SHORT:
            begin
                raw_stream.push_back({mask_on, len[6:0]});
            end
            LEN_EXT16:
            begin
                raw_stream.push_back({mask_on, LEN_CODE16});
                raw_stream.push_back(len[15:8]);
                raw_stream.push_back(len[7:0]);
            end
            default:
            begin
                raw_stream.push_back({mask_on, LEN_CODE64});
                for (int i = 7; i >= 0; i--)
                    raw_stream.push_back(len[8*i +: 8]);
            end
        endcase
        if (mask_on)
            repeat (4) raw_stream.push_back(8'($urandom));
        repeat (payload_count) raw_stream.push_back(8'($urandom));
    endtask

    task automatic add_random_frame();
        logic [63:0] len;
        len_form_e   form;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        form = LEN_SHORT;
        if (roll < 45)
        begin
            len = 64'($urandom_range(0, 8));
        end
        else if (roll < 80)
        begin
            len = 64'($urandom_range(9, 125));
        end
        else
        begin
            form = LEN_EXT16;
            len = ($urandom_range(0, 3) == 0) ? 64'(LEN16_MIN)
                                              : 64'($urandom_range(127, 400));
        end
        add_frame(random_hdr1(), 1'($urandom), len, form, int'(len));
    endtask

    // request side: hold each byte until taken, random gaps between bytes
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 199) == 0)
                drv_quiet = !drv_quiet;
            if (in_fire)
            begin
                void'(raw_stream.pop_front());
                drv_gap = pick_gap(drv_quiet);
            end
            if (drv_gap > 0)
            begin
                drv_gap--;
                byte_in.valid <= 1'b0;
                byte_in.data_byte <= 8'($urandom);
            end
            else if (raw_stream.size() != 0)
            begin
                byte_in.valid <= 1'b1;
                byte_in.data_byte <= raw_stream[0];
            end
            else
            begin
                byte_in.valid <= 1'b0;
                byte_in.data_byte <= 8'($urandom);
            end
        end
    end

    // result side: random stalls plus two long hold-offs to back up the input
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            sink_cycles++;
            if ($urandom_range(0, 199) == 0)
                sink_quiet = !sink_quiet;
            if (sink_cycles == 600 || sink_cycles == 1500)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                frame_out.ready <= 1'b0;
            end
            else if (sink_stall > 0)
            begin
                sink_stall--;
                frame_out.ready <= 1'b0;
            end
            else
            begin
                frame_out.ready <= 1'b1;
                sink_stall = pick_gap(sink_quiet);
            end
        end
    end

    always @(posedge clk)
    begin : monitor_blk
        wfp_result_t want;
        wfp_result_t predicted;
        if (rst_n && frame_out.valid && frame_out.ready)
        begin
            if (parsed_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = parsed_results.pop_front();
                check_field("payload_valid", 64'(want.payload_valid),
                            64'(frame_out.payload_valid));
                check_field("payload_byte", 64'(want.payload_byte),
                            64'(frame_out.payload_byte));
                check_field("payload_last", 64'(want.payload_last),
                            64'(frame_out.payload_last));
                check_field("header_done", 64'(want.header_done),
                            64'(frame_out.header_done));
                check_field("frame_done", 64'(want.frame_done),
                            64'(frame_out.frame_done));
                check_field("fin_flag", 64'(want.fin_flag), 64'(frame_out.fin_flag));
                check_field("frame_opcode", 64'(want.frame_opcode),
                            64'(frame_out.frame_opcode));
                check_field("masked", 64'(want.masked), 64'(frame_out.masked));
                check_field("decoded_length", 64'(want.decoded_length),
                            64'(frame_out.decoded_length));
                check_field("error", 64'(want.error), 64'(frame_out.error));
            end
        end
        if (rst_n && byte_in.valid && byte_in.ready)
        begin
            parse_ws_byte(byte_in.data_byte, predicted);
            parsed_results.push_back(predicted);
        end
        in_fire <= rst_n && byte_in.valid && byte_in.ready;
    end

    initial
    begin : stimulus_blk
        stream_end_e last_kind;
        logic [63:0] len;
        int unsigned random_start;
        rst_n = 1'b0;
        byte_in.valid = 1'b0;
        byte_in.data_byte = 8'h00;
        frame_out.ready = 1'b0;

        // every opcode as an empty frame, fin and mask varied
        for (int op = 0; op <= OPCODE_MAX; op++)
            add_frame({op[0], 3'b000, 4'(op)}, op[1], 64'd0, LEN_SHORT, 0);
        // key wraps round within a short masked frame
        add_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, 64'd5, LEN_SHORT, 5);

        random_start = raw_stream.size();
        while (raw_stream.size() < random_start + 1050)
            add_random_frame();

        // error is sticky and reset comes once, so the stream ends on one bad header
        // or on a frame too long to finish
        last_kind = stream_end_e'($urandom_range(0, 5));
        case (last_kind)
            END_RSV:
                raw_stream.push_back({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
            END_OPCODE:
                raw_stream.push_back({1'($urandom), 3'b000,
                                      4'($urandom_range(OPCODE_MAX + 1, 15))});
            END_LEN16_SHORT:
                add_frame(random_hdr1(), 1'($urandom), 64'($urandom_range(0, 125)),
                          LEN_EXT16, 0);
            END_LEN64_SMALL:
                add_frame(random_hdr1(), 1'($urandom), 64'($urandom_range(0, 65535)),
                          LEN_EXT64, 0);
            END_LEN64_TOP:
                add_frame(random_hdr1(), 1'($urandom), {1'b1, 31'($urandom), 32'($urandom)},
                          LEN_EXT64, 0);
            default:
            begin
                len = {1'b0, 31'($urandom), 32'($urandom)};
                if (len < 64'd65536 || $urandom_range(0, 3) == 0)
                    len = {1'b0, {63{1'b1}}};
                add_frame(random_hdr1(), 1'($urandom), len, LEN_EXT64, 20);
            end
        endcase
        repeat (20) raw_stream.push_back(8'($urandom));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (raw_stream.size() != 0)
            @(posedge clk);
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_websocket_frame_parser_unit passed");
        else
            $display("tb_websocket_frame_parser_unit failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb_websocket_frame_parser_unit failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/wfp_pkg.sv
hdl/wfp_if.sv
hdl/wfp_parse_core.sv
hdl/wfp_result_reg.sv
hdl/websocket_frame_parser_unit.sv
tb/sv/tb_websocket_frame_parser_unit.sv
